/* hw/rtl/cmac_pkg.sv */
// Package for the AES-256 CMAC core: S-box, types and constants.
// No dependencies.
package cmac_pkg;

  localparam int BlockW = 128;
  localparam int KeyW   = 256;
  localparam logic [7:0] CmacRb  = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [1:0] CfgKey0 = 2'd0;
  localparam logic [1:0] CfgKey1 = 2'd1;
  localparam logic [1:0] CfgKey2 = 2'd2;
  localparam logic [1:0] CfgKey3 = 2'd3;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        last_block;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } out_beat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One full round without the key add; last round skips MixColumns.
  function automatic block_t aes_round(input block_t s, input logic mix);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] x;
    block_t r;
    for (int k = 0; k < 16; k++) a[k] = sbox(s[127-8*k -: 8]);
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[k+4*c] = a[k + 4*((c+k) % 4)];
    for (int c = 0; c < 4; c++) begin
      x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      o[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
      o[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
      o[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
      o[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int k = 0; k < 16; k++) r[127-8*k -: 8] = mix ? o[k] : t[k];
    return r;
  endfunction

  // GF(2^128) doubling for subkey generation.
  function automatic block_t dbl(input block_t v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CmacRb : 8'h00)};
  endfunction

endpackage

/* hw/rtl/cmac_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
// Payload type is a parameter; used with types from cmac_pkg.
interface cmac_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/cmac_aes256_mac_core.sv */
// AES-256 CMAC core: key schedule, subkey derivation and block chaining.
// Depends on cmac_pkg and cmac_stream_if.
//
// Usage: write the four 64-bit key words through cfg_we/cfg_index/cfg_wdata
// while idle. Message blocks arrive on the in_s channel, one 16-byte block
// per beat; last_block marks the final one and byte_count gives its length.
// The tag leaves on out_s, one beat per message.
// A block is accepted, given the initial key add, taken through 14 rounds at one
// a cycle, and finally written back as the chaining value or loaded as the
// tag. A new block is not taken until the last one is written back or its
// tag is loaded.
// After reset or a key write the first block first waits for key
// expansion: 52 round-key words, one a cycle, then a pass that enciphers
// the zero block for the subkeys.
// Round keys are held as fifteen 128-bit rows, one row read per round.
// Reset clears the chaining value and marks the keys stale. A stalled
// receiver holds the tag in the output register; the next block may be
// taken and processed meanwhile, but a second tag waits for the first.
module cmac_aes256_mac_core
  import cmac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  cmac_stream_if.sink   in_s,
  cmac_stream_if.source out_s
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]      state;
  logic [KeyW-1:0] key;
  logic            keys_ready;
  // Round keys as 15 registered 128-bit rows; each written once per sweep
  // at a fixed place, read by the round counter.
  block_t          rk [15];
  logic [KeyW-1:0] win;          // sliding window of last eight words
  logic [5:0]      wcnt;
  logic [3:0]      rnd;
  block_t          st, chain, k1, k2, pend;
  logic            pend_last, sub_pass;
  in_beat_t        hold;
  logic            out_valid;
  out_beat_t       out_data;
  logic            tag_load;

  logic [31:0] w_new, t_w;
  logic [7:0]  rc;
  block_t      msg, padded, mask;
  logic [4:0]  cnt;

  // Next key-schedule word from the eight-word window.
  always_comb begin
    t_w = win[31:0];
    case (wcnt[2:0])
      3'd0: t_w = sub_word({win[23:0], win[31:24]}) ^ {rc, 24'd0};
      3'd4: t_w = sub_word(win[31:0]);
      default: t_w = win[31:0];
    endcase
    w_new = win[255:224] ^ t_w;
  end

  always_comb begin
    case (wcnt[5:3])
      3'd1: rc = 8'h01;
      3'd2: rc = 8'h02;
      3'd3: rc = 8'h04;
      3'd4: rc = 8'h08;
      3'd5: rc = 8'h10;
      3'd6: rc = 8'h20;
      3'd7: rc = 8'h40;
      default: rc = 8'h00;
    endcase
  end

  // Last-block padding and subkey selection.
  always_comb begin
    cnt = (hold.byte_count > 5'd16) ? 5'd16 : hold.byte_count;
    msg = {hold.block_high, hold.block_low};
    mask = '0;
    for (int i = 0; i < 16; i++)
      if (5'(i) < cnt) mask[127-8*i -: 8] = 8'hff;
    padded = msg & mask;
    for (int i = 0; i < 16; i++)
      if (5'(i) == cnt) padded[127-8*i -: 8] = PadByte;
    if (!hold.last_block) pend = msg;
    else if (cnt == 5'd16) pend = msg ^ k1;
    else pend = padded ^ k2;
  end

  // Tag register load when the output slot is free or being emptied.
  assign tag_load = (state == StDone) && !sub_pass && pend_last &&
                    (!out_valid || out_s.ready);

  assign in_s.ready = (state == StIdle);
  assign out_s.valid = out_valid;
  assign out_s.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= StIdle;
      key        <= '0;
      keys_ready <= 1'b0;
      chain      <= '0;
      out_valid  <= 1'b0;
      sub_pass   <= 1'b0;
      wcnt       <= '0;
      rnd        <= '0;
      pend_last  <= 1'b0;
    end else begin
      if (tag_load) out_valid <= 1'b1;
      else if (out_valid && out_s.ready) out_valid <= 1'b0;
      if (cfg_we) begin
        keys_ready <= 1'b0;
        case (cfg_index)
          CfgKey0: key[255:192] <= cfg_wdata;
          CfgKey1: key[191:128] <= cfg_wdata;
          CfgKey2: key[127:64]  <= cfg_wdata;
          CfgKey3: key[63:0]    <= cfg_wdata;
          default: ;
        endcase
      end else if (state == StDone && sub_pass) begin
        keys_ready <= 1'b1;
      end
      case (state)
        StIdle: begin
          if (in_s.valid && in_s.ready) begin
            hold <= in_s.data;
            if (!keys_ready) begin
              win   <= key;
              rk[0] <= key[255:128];
              rk[1] <= key[127:0];
              wcnt  <= 6'd8;
              state <= StExp;
            end else state <= StLoad;
          end
        end
        StExp: begin
          // One new schedule word per cycle; a row closes every fourth.
          win  <= {win[223:0], w_new};
          wcnt <= wcnt + 6'd1;
          if (wcnt[1:0] == 2'd3)
            rk[wcnt[5:2]] <= {win[95:0], w_new};
          if (wcnt == 6'd59) begin
            st       <= rk[0];
            rnd      <= 4'd1;
            sub_pass <= 1'b1;
            state    <= StRun;
          end
        end
        StLoad: begin
          st        <= chain ^ pend ^ rk[0];
          pend_last <= hold.last_block;
          rnd       <= 4'd1;
          state     <= StRun;
        end
        StRun: begin
          st  <= aes_round(st, rnd != 4'd14) ^ rk[rnd];
          rnd <= rnd + 4'd1;
          if (rnd == 4'd14) state <= StDone;
        end
        StDone: begin
          if (sub_pass) begin
            k1       <= dbl(st);
            k2       <= dbl(dbl(st));
            sub_pass <= 1'b0;
            state    <= StLoad;
          end else if (tag_load) begin
            out_data <= '{tag_high: st[127:64], tag_low: st[63:0]};
            chain    <= '0;
            state    <= StIdle;
          end else if (!pend_last) begin
            chain <= st;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the AES-256 CMAC core: directed and random messages.
// Tags are predicted by an in-bench AES-256/CMAC model and compared in order.
// Depends on cmac_pkg, cmac_stream_if and cmac_aes256_mac_core.
module tb_top;
  import cmac_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CfgKey0;
  logic [63:0] cfg_wdata = '0;

  cmac_stream_if #(.payload_t(in_beat_t))  blk_ch ();
  cmac_stream_if #(.payload_t(out_beat_t)) tag_ch ();

  cmac_aes256_mac_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_s(blk_ch.sink), .out_s(tag_ch.source)
  );

  always #2 clk = ~clk;

  // Bench copy of key, chaining value and derived keys
  logic [63:0] key_q [4];
  block_t      chain_q, k1_q, k2_q;
  logic [31:0] rk_q [60];
  logic        keys_ok;
  out_beat_t   tag_q [$];

  int  mism = 0;
  int  idle_cnt = 0;
  bit  tx_jitter = 1'b1;
  bit  rx_jitter = 1'b1;
  int  hold_cycles = 0;

  function automatic logic [7:0] sb(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] r;
    logic [7:0] p;
    inv = 8'h00;
    // multiplicative inverse by search, then the affine map
    for (int i = 1; i < 256; i++) begin
      logic [7:0] x, y, m;
      x = a; y = i[7:0]; m = 8'h00;
      for (int b = 0; b < 8; b++) begin
        if (y[b]) m ^= x;
        x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      if (m == 8'h01) inv = i[7:0];
    end
    p = inv;
    r = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]};
    return r ^ 8'h63;
  endfunction

  logic [7:0] sbt [256];
  initial for (int i = 0; i < 256; i++) sbt[i] = sb(i[7:0]);

  function automatic logic [7:0] mul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t aes_enc(input block_t blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
    for (int r = 0; r <= 14; r++) begin
      if (r > 0) begin
        for (int k = 0; k < 16; k++) s[k] = sbt[s[k]];
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++) t[k+4*c] = s[k + 4*((c+k) & 3)];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          if (r < 14) begin
            al = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
            s[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
            s[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
            s[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
          end else begin
            s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) s[4*c+k] ^= rk_q[4*r+c][31-8*k -: 8];
    end
    for (int k = 0; k < 16; k++) aes_enc[127-8*k -: 8] = s[k];
  endfunction

  function automatic block_t gf_double(input block_t v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
  endfunction

  function automatic void expand_key();
    logic [31:0] w;
    for (int i = 0; i < 8; i++) rk_q[i] = key_q[i/2][(i%2 ? 31 : 63) -: 32];
    for (int i = 8; i < 60; i++) begin
      w = rk_q[i-1];
      if (i % 8 == 0) begin
        w = {w[23:0], w[31:24]};
        w = {sbt[w[31:24]], sbt[w[23:16]], sbt[w[15:8]], sbt[w[7:0]]};
        w[31:24] ^= 8'h01 << (i/8 - 1);
      end else if (i % 8 == 4) begin
        w = {sbt[w[31:24]], sbt[w[23:16]], sbt[w[15:8]], sbt[w[7:0]]};
      end
      rk_q[i] = rk_q[i-8] ^ w;
    end
    k1_q = gf_double(aes_enc('0));
    k2_q = gf_double(k1_q);
    keys_ok = 1'b1;
  endfunction

  // Advance the CMAC state by one block, queueing a tag on the last one
  function automatic void cmac_absorb(input in_beat_t b);
    block_t m;
    int     n;
    out_beat_t o;
    if (!keys_ok) expand_key();
    m = {b.block_high, b.block_low};
    if (!b.last_block) begin
      chain_q = aes_enc(chain_q ^ m);
      return;
    end
    n = (b.byte_count > 16) ? 16 : b.byte_count;
    if (n == 16) m ^= k1_q;
    else begin
      for (int k = n; k < 16; k++) m[127-8*k -: 8] = (k == n) ? PadByte : 8'h00;
      m ^= k2_q;
    end
    {o.tag_high, o.tag_low} = aes_enc(chain_q ^ m);
    tag_q.push_back(o);
    chain_q = '0;
  endfunction

  // Compare each tag beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && tag_ch.valid && tag_ch.ready) begin
      if (tag_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected tag %h %h", tag_ch.data.tag_high, tag_ch.data.tag_low);
      end else begin
        if (tag_ch.data.tag_high !== tag_q[0].tag_high ||
            tag_ch.data.tag_low !== tag_q[0].tag_low) begin
          mism++;
          if (mism <= 10)
            $display("tag mismatch: exp %h %h got %h %h", tag_q[0].tag_high,
                     tag_q[0].tag_low, tag_ch.data.tag_high, tag_ch.data.tag_low);
        end
        void'(tag_q.pop_front());
      end
    end
  end

  // Receiver ready with random stall bursts and an optional long hold
  initial begin
    int n;
    tag_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_cycles > 0) begin
        tag_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        tag_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        tag_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((blk_ch.valid && blk_ch.ready) || (tag_ch.valid && tag_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_q[idx] = val;
    keys_ok = 1'b0;
  endtask

  task automatic load_key(input logic [63:0] a, b, c, d);
    write_key(CfgKey0, a); write_key(CfgKey1, b);
    write_key(CfgKey2, c); write_key(CfgKey3, d);
  endtask

  // Send one block beat; the prediction is made at acceptance
  task automatic send_block(input in_beat_t b);
    int n;
    if (tx_jitter && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      blk_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    blk_ch.valid <= 1'b1;
    blk_ch.data  <= b;
    @(posedge clk);
    while (!blk_ch.ready) @(posedge clk);
    cmac_absorb(b);
  endtask

  task automatic drain();
    blk_ch.valid <= 1'b0;
    @(posedge clk);
    while (tag_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_beat_t rnd_block(input bit last, input int cnt);
    in_beat_t b;
    b.block_high = rnd64(); b.block_low = rnd64();
    b.byte_count = cnt[4:0]; b.last_block = last;
    return b;
  endfunction

  // Directed rows: data, count, last
  typedef struct {
    logic [63:0] hi, lo;
    logic [4:0]  cnt;
    logic        last;
  } row_t;

  row_t rows [] = '{
    '{64'h0, 64'h0, 5'd0, 1'b1},                       // empty message
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1},
    '{64'h0, 64'h0, 5'd16, 1'b1},
    '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1},
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1, 1'b1}, // bytes past count
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd15, 1'b1},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b1}, // count above 16
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17, 1'b1},
    '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd3, 1'b0}, // count ignored
    '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd0, 1'b0},
    '{64'h1111111111111111, 64'h2222222222222222, 5'd8, 1'b1},
    '{64'hffffffffffffffff, 64'h0, 5'd31, 1'b0},
    '{64'h0, 64'hffffffffffffffff, 5'd7, 1'b1}
  };

  initial begin
    in_beat_t b;
    int       len, sent;
    blk_ch.valid = 1'b0;
    blk_ch.data  = '0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    chain_q = '0;
    keys_ok = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the all-zero key, then a fixed 256-bit test key
    foreach (rows[i]) send_block('{rows[i].hi, rows[i].lo, rows[i].cnt, rows[i].last});
    drain();
    load_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781,
             64'h1f352c073b6108d7, 64'h2d9810a30914dff4);
    send_block('{64'h0, 64'h0, 5'd0, 1'b1});
    drain();
    send_block('{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1});
    // key write inside a message keeps the chaining value
    send_block('{64'h1, 64'h2, 5'd16, 1'b0});
    drain();
    write_key(CfgKey2, 64'hffffffffffffffff);
    send_block('{64'h3, 64'h4, 5'd5, 1'b1});
    drain();

    // Random messages, with key changes between phases
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_key('1, '1, '1, '1);
        1: load_key('0, '0, '0, '0);
        default: load_key(rnd64(), rnd64(), rnd64(), rnd64());
      endcase
      if (ph == 2) hold_cycles = 600;
      if (ph == 5) begin
        tx_jitter = 1'b0; rx_jitter = 1'b0;
      end
      for (int m = 0; m < 30; m++) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          b = rnd_block(k == len - 1, $urandom_range(0, 31));
          if ($urandom_range(0, 5) == 0) b.byte_count = 5'($urandom_range(0, 16));
          send_block(b);
          sent++;
        end
      end
      drain();
    end

    if (mism == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/cmac_pkg.sv
hw/rtl/cmac_stream_if.sv
hw/rtl/cmac_aes256_mac_core.sv
bench/tb_top.sv
